/* rtl/assert_macros.svh */
// Assertion macros used by the finder top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define ASSERT_NEVER(name, clk, rst, cond) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_CLK(name, clk, rst, prop)
`define ASSERT_NEVER(name, clk, rst, cond)
`endif
`endif

/* rtl/msq_pkg.sv */
// Shared constants and types of the largest all-ones square finder.
package msq_pkg;

   localparam int MAX_ROWS_DEF = 64;
   localparam int MAX_COLS_DEF = 64;

   localparam int DIM_W       = 7;
   localparam int SIZE_OUT_W  = 7;
   localparam int POS_OUT_W   = 6;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 24;
   localparam int CSR_INDEX_W = 1;
   localparam int DIM_RESET   = 64;

   localparam logic [CSR_INDEX_W-1:0] CSR_MATRIX_ROWS = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MATRIX_COLS = 1'b1;

   typedef struct packed {
      logic first_row;
      logic first_col;
      logic last_cell;
   } cell_flags_type;

   typedef struct packed {
      logic [SIZE_OUT_W-1:0] square_size;
      logic [POS_OUT_W-1:0]  top_row;
      logic [POS_OUT_W-1:0]  left_col;
   } result_type;

endpackage

/* rtl/msq_line_store.sv */
// Line store of the previous row's square sides, one read and one write port.
module msq_line_store #(
   parameter int DEPTH  = msq_pkg::MAX_COLS_DEF,
   parameter int DATA_W = 7
) (
   input  logic                                     clock,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [DATA_W-1:0]                        rd_data,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [DATA_W-1:0]                        wr_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/msq_corner.sv */
// Per-cell square side update and tracking of the best square.
module msq_corner #(
   parameter int MAX_ROWS = msq_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS = msq_pkg::MAX_COLS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   cell_bit,
   input  logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] row,
   input  logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] col,
   input  logic [$clog2(((MAX_ROWS < MAX_COLS) ? MAX_ROWS : MAX_COLS) + 1)-1:0] up,
   input  msq_pkg::cell_flags_type flags,
   output logic [$clog2(((MAX_ROWS < MAX_COLS) ? MAX_ROWS : MAX_COLS) + 1)-1:0] side,
   output msq_pkg::result_type    result
);

   localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int SIZE_W = $clog2(((MAX_ROWS < MAX_COLS) ? MAX_ROWS : MAX_COLS) + 1);

   logic [SIZE_W-1:0] left_ff, left_in;
   logic [SIZE_W-1:0] upleft_ff, upleft_in;
   logic [SIZE_W-1:0] best_size_ff, best_size_in;
   logic [ROW_W-1:0]  best_top_ff, best_top_in;
   logic [COL_W-1:0]  best_left_ff, best_left_in;

   logic [SIZE_W-1:0] up_m;
   logic [SIZE_W-1:0] lft_m;
   logic [SIZE_W-1:0] ul_m;
   logic [SIZE_W-1:0] min_a;
   logic [SIZE_W-1:0] min_b;
   logic [ROW_W:0]    top_wide;
   logic [COL_W:0]    lc_wide;
   logic [ROW_W-1:0]  top;
   logic [COL_W-1:0]  lc;
   logic              better;
   logic [SIZE_W-1:0] res_size;
   logic [ROW_W-1:0]  res_top;
   logic [COL_W-1:0]  res_left;

   always_comb begin
      up_m  = flags.first_row ? '0 : up;
      lft_m = flags.first_col ? '0 : left_ff;
      ul_m  = (flags.first_row || flags.first_col) ? '0 : upleft_ff;
      min_a = (up_m < lft_m) ? up_m : lft_m;
      min_b = (min_a < ul_m) ? min_a : ul_m;
      side  = cell_bit ? (min_b + SIZE_W'(1)) : '0;

      top_wide = {1'b0, row} + (ROW_W+1)'(1) - (ROW_W+1)'(side);
      lc_wide  = {1'b0, col} + (COL_W+1)'(1) - (COL_W+1)'(side);
      top      = top_wide[ROW_W-1:0];
      lc       = lc_wide[COL_W-1:0];

      better = (side != '0) &&
               ((side > best_size_ff) ||
                ((side == best_size_ff) &&
                 ((lc < best_left_ff) || ((lc == best_left_ff) && (top < best_top_ff)))));

      res_size = better ? side : best_size_ff;
      res_top  = better ? top  : best_top_ff;
      res_left = better ? lc   : best_left_ff;

      result.square_size = msq_pkg::SIZE_OUT_W'(res_size);
      result.top_row     = msq_pkg::POS_OUT_W'(res_top);
      result.left_col    = msq_pkg::POS_OUT_W'(res_left);

      left_in      = left_ff;
      upleft_in    = upleft_ff;
      best_size_in = best_size_ff;
      best_top_in  = best_top_ff;
      best_left_in = best_left_ff;
      if (adv) begin
         if (flags.last_cell) begin
            left_in      = '0;
            upleft_in    = '0;
            best_size_in = '0;
            best_top_in  = '0;
            best_left_in = '0;
         end else begin
            left_in      = side;
            upleft_in    = up_m;
            best_size_in = res_size;
            best_top_in  = res_top;
            best_left_in = res_left;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff      <= '0;
         upleft_ff    <= '0;
         best_size_ff <= '0;
         best_top_ff  <= '0;
         best_left_ff <= '0;
      end else begin
         left_ff      <= left_in;
         upleft_ff    <= upleft_in;
         best_size_ff <= best_size_in;
         best_top_ff  <= best_top_in;
         best_left_ff <= best_left_in;
      end
   end

endmodule

/* rtl/max_all_ones_square_finder.sv */
// Largest all-ones square finder over a row-major stream of matrix cells.
// One cell per cycle unless a result stalls, set by one line store read and write.
// The result of a matrix is registered once its last cell has passed stages one and two.
// A stalled result does not block cells of the next matrix until its last cell arrives.
// Synchronous reset sets dimensions to min(64, maximum) and clears scan and best square.
// The line store is not cleared; the first row of each matrix never uses its contents.
`include "assert_macros.svh"

module max_all_ones_square_finder #(
   parameter int MAX_ROWS = msq_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS = msq_pkg::MAX_COLS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [0] cell_bit
   input  logic [msq_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [6:0] square_size, [12:7] top_row, [18:13] left_col
   output logic [msq_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_we,
   input  logic [msq_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [msq_pkg::DIM_W-1:0]         csr_wdata
);

   localparam int ROW_W      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COL_W      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int ROW_CNT_W  = $clog2(MAX_ROWS + 1);
   localparam int COL_CNT_W  = $clog2(MAX_COLS + 1);
   localparam int SIZE_W     = $clog2(((MAX_ROWS < MAX_COLS) ? MAX_ROWS : MAX_COLS) + 1);
   localparam int ROWS_RESET = (msq_pkg::DIM_RESET > MAX_ROWS) ? MAX_ROWS : msq_pkg::DIM_RESET;
   localparam int COLS_RESET = (msq_pkg::DIM_RESET > MAX_COLS) ? MAX_COLS : msq_pkg::DIM_RESET;
   localparam int PAD_W      = msq_pkg::RSP_DATA_W - msq_pkg::SIZE_OUT_W
                               - 2 * msq_pkg::POS_OUT_W;

   logic [ROW_CNT_W-1:0] rows_ff, rows_in;
   logic [COL_CNT_W-1:0] cols_ff, cols_in;
   logic [ROW_CNT_W-1:0] rows_wr;
   logic [COL_CNT_W-1:0] cols_wr;

   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [COL_W:0]   col_plus;
   logic [ROW_W:0]   row_plus;
   logic             col_last;
   logic             row_last;

   logic                    s1_valid_ff, s1_valid_in;
   logic                    s1_bit_ff, s1_bit_in;
   logic [ROW_W-1:0]        s1_row_ff, s1_row_in;
   logic [COL_W-1:0]        s1_col_ff, s1_col_in;
   msq_pkg::cell_flags_type s1_flags_ff, s1_flags_in;
   logic                    s1_fwd_ff, s1_fwd_in;
   logic [SIZE_W-1:0]       s1_fwd_data_ff, s1_fwd_data_in;

   logic                    s2_valid_ff, s2_valid_in;
   logic                    s2_bit_ff, s2_bit_in;
   logic [ROW_W-1:0]        s2_row_ff, s2_row_in;
   logic [COL_W-1:0]        s2_col_ff, s2_col_in;
   msq_pkg::cell_flags_type s2_flags_ff, s2_flags_in;
   logic [SIZE_W-1:0]       s2_up_ff, s2_up_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   msq_pkg::result_type     rsp_result_ff, rsp_result_in;

   logic                    accept;
   logic                    s1_move;
   logic                    s2_take;
   logic                    s2_adv;
   logic [COL_W-1:0]        s1_next_col;
   logic [SIZE_W-1:0]       rd_data;
   logic [SIZE_W-1:0]       s1_up;
   logic [SIZE_W-1:0]       side;
   msq_pkg::cell_flags_type new_flags;
   msq_pkg::result_type     result;

   // Configuration writes store the dimension already clamped to its legal range.
   always_comb begin
      if (csr_wdata == '0) begin
         rows_wr = ROW_CNT_W'(1);
         cols_wr = COL_CNT_W'(1);
      end else begin
         rows_wr = (int'(csr_wdata) > MAX_ROWS) ? ROW_CNT_W'(MAX_ROWS) : ROW_CNT_W'(csr_wdata);
         cols_wr = (int'(csr_wdata) > MAX_COLS) ? COL_CNT_W'(MAX_COLS) : COL_CNT_W'(csr_wdata);
      end
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (csr_we) begin
         case (csr_index)
            msq_pkg::CSR_MATRIX_ROWS: rows_in = rows_wr;
            msq_pkg::CSR_MATRIX_COLS: cols_in = cols_wr;
            default: ;
         endcase
      end
   end

   always_comb begin
      s2_adv     = s2_valid_ff && (!s2_flags_ff.last_cell || !rsp_valid_ff || rsp_tready);
      s2_take    = !s2_valid_ff || s2_adv;
      s1_move    = s1_valid_ff && s2_take;
      req_tready = !s1_valid_ff || s1_move;
      accept     = req_tvalid && req_tready;

      col_plus = {1'b0, col_ff} + (COL_W+1)'(1);
      row_plus = {1'b0, row_ff} + (ROW_W+1)'(1);
      col_last = col_plus >= (COL_W+1)'(cols_ff);
      row_last = row_plus >= (ROW_W+1)'(rows_ff);

      new_flags.first_row = (row_ff == '0);
      new_flags.first_col = (col_ff == '0);
      new_flags.last_cell = col_last && row_last;

      row_in = row_ff;
      col_in = col_ff;
      if (accept) begin
         if (col_last) begin
            col_in = '0;
            row_in = row_last ? '0 : row_plus[ROW_W-1:0];
         end else begin
            col_in = col_plus[COL_W-1:0];
         end
      end

      s1_valid_in = accept || (s1_valid_ff && !s1_move);
      s1_bit_in   = accept ? req_tdata[0] : s1_bit_ff;
      s1_row_in   = accept ? row_ff : s1_row_ff;
      s1_col_in   = accept ? col_ff : s1_col_ff;
      s1_flags_in = accept ? new_flags : s1_flags_ff;
      s1_next_col = accept ? col_ff : s1_col_ff;

      // A write to the entry that the waiting cell has read replaces the stale read data.
      if (s2_adv && (s2_col_ff == s1_next_col)) begin
         s1_fwd_in      = 1'b1;
         s1_fwd_data_in = side;
      end else begin
         s1_fwd_in      = accept ? 1'b0 : s1_fwd_ff;
         s1_fwd_data_in = s1_fwd_data_ff;
      end
      s1_up = s1_fwd_ff ? s1_fwd_data_ff : rd_data;

      s2_valid_in = s1_move || (s2_valid_ff && !s2_adv);
      s2_bit_in   = s1_move ? s1_bit_ff : s2_bit_ff;
      s2_row_in   = s1_move ? s1_row_ff : s2_row_ff;
      s2_col_in   = s1_move ? s1_col_ff : s2_col_ff;
      s2_flags_in = s1_move ? s1_flags_ff : s2_flags_ff;
      if (s1_move) begin
         s2_up_in = (s2_adv && (s2_col_ff == s1_col_ff)) ? side : s1_up;
      end else begin
         s2_up_in = s2_up_ff;
      end

      rsp_valid_in  = (s2_adv && s2_flags_ff.last_cell) || (rsp_valid_ff && !rsp_tready);
      rsp_result_in = (s2_adv && s2_flags_ff.last_cell) ? result : rsp_result_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff      <= ROW_CNT_W'(ROWS_RESET);
         cols_ff      <= COL_CNT_W'(COLS_RESET);
         row_ff       <= '0;
         col_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         s1_fwd_ff    <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         s1_valid_ff  <= s1_valid_in;
         s1_fwd_ff    <= s1_fwd_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_bit_ff      <= s1_bit_in;
      s1_row_ff      <= s1_row_in;
      s1_col_ff      <= s1_col_in;
      s1_flags_ff    <= s1_flags_in;
      s1_fwd_data_ff <= s1_fwd_data_in;
      s2_bit_ff      <= s2_bit_in;
      s2_row_ff      <= s2_row_in;
      s2_col_ff      <= s2_col_in;
      s2_flags_ff    <= s2_flags_in;
      s2_up_ff       <= s2_up_in;
      rsp_result_ff  <= rsp_result_in;
   end

   msq_line_store #(
      .DEPTH  (MAX_COLS),
      .DATA_W (SIZE_W)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (rd_data),
      .wr_en   (s2_adv),
      .wr_addr (s2_col_ff),
      .wr_data (side)
   );

   msq_corner #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_corner (
      .clock    (clock),
      .reset    (reset),
      .adv      (s2_adv),
      .cell_bit (s2_bit_ff),
      .row      (s2_row_ff),
      .col      (s2_col_ff),
      .up       (s2_up_ff),
      .flags    (s2_flags_ff),
      .side     (side),
      .result   (result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_result_ff.left_col, rsp_result_ff.top_row,
                        rsp_result_ff.square_size};

   `ASSERT_CLK(a_s1_drains, clock, reset, (s1_valid_ff && !s2_valid_ff) |=> s2_valid_ff)
   `ASSERT_CLK(a_rsp_source, clock, reset, $rose(rsp_valid_ff) |-> $past(s2_valid_ff && s2_flags_ff.last_cell))
   `ASSERT_CLK(a_accept_lands, clock, reset, accept |=> s1_valid_ff)
   `ASSERT_NEVER(a_no_side_on_zero, clock, reset, s2_valid_ff && !s2_bit_ff && (side != '0))

endmodule
